@@ design/pcg_pkg.sv @@
package pcg_pkg;

  // Fixed field widths
  localparam int unsigned PartW  = 9;
  localparam int unsigned CountW = 63;

  // Smallest part size that is folded into the table
  localparam int unsigned FirstPart = 2;

  typedef struct packed {
    logic load;        // capture n, restart the index
    logic init;        // write one at the current index, advance
    logic fold_start;  // set part size and index to the first folded part
    logic fold;        // read both operands, schedule the write-back, advance
    logic rd_res;      // read the entry at n
    logic cap;         // load the output register from the read data
  } cmd_t;

  typedef struct packed {
    logic j_last;      // index has reached n
    logic fold_last;   // last update of the last part size
    logic n_small;     // n is zero or one: nothing to fold
  } status_t;

endpackage

@@ design/partition_count_generating_dp.sv @@
// Partition counter: returns p(n), the number of unordered partitions of n.
// Input channel (in_valid_i / in_ready_o) carries part_total_i; values above
// MAX_N are clamped to MAX_N. Output channel (out_valid_o / out_ready_i)
// carries partition_count_o. One word in gives exactly one word out.
// Work: a table of MAX_N+1 counts in a two-read, one-write memory is set to
// one for indexes 0..n, then every part size s = 2..n is folded in with
// table[j] += table[j-s], one update per cycle through the shared adder.
// From accept to result valid, the table is set to ones, every part size is
// folded in, a drain state lets the last write-back land, the result entry is
// read and then captured; for n of zero or one the fold and the drain are
// skipped. The single memory update per cycle sets the length of the work.
// One word is worked at a time; in_ready_o is high only between words.
// The result sits in an output register, so the next word is taken while an
// earlier result still waits; a stalled receiver holds the result and stops
// the next word only at its very end, before the result register is loaded.
// Reset clears the controller and the output valid; the table needs no clear.
module partition_count_generating_dp
  import pcg_pkg::*;
#(
  parameter int unsigned MAX_N = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PartW-1:0]  part_total_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] partition_count_o
);

  cmd_t    cmd;
  status_t status;

  pcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcg_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .part_total_i      (part_total_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .partition_count_o (partition_count_o)
  );

endmodule

@@ design/pcg_ctrl.sv @@
module pcg_ctrl
  import pcg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StFold  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StWait  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = StInit;
        end
      end
      StInit: begin
        cmd.init = 1'b1;
        if (status_i.j_last) begin
          if (status_i.n_small) begin
            state_d = StRead;
          end else begin
            cmd.fold_start = 1'b1;
            state_d        = StFold;
          end
        end
      end
      StFold: begin
        cmd.fold = 1'b1;
        if (status_i.fold_last) begin
          state_d = StDrain;
        end
      end
      // let the last write-back land before reading the answer
      StDrain: begin
        state_d = StRead;
      end
      StRead: begin
        cmd.rd_res = 1'b1;
        state_d    = StWait;
      end
      StWait: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.cap = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.cap) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_cap_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cap |-> (!out_valid_q || out_ready_i))
    else $error("result captured over an untaken word");

  a_accept_starts_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StInit))
    else $error("accepted word did not start table init");

  a_drain_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFold && status_i.fold_last) |=> ##1 (state_q == StRead))
    else $error("result read did not follow the drain cycle");

endmodule

@@ design/pcg_dp.sv @@
module pcg_dp
  import pcg_pkg::*;
#(
  parameter int unsigned MAX_N = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PartW-1:0]  part_total_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic [CountW-1:0] partition_count_o
);

  localparam int unsigned IdxW = $clog2(MAX_N + 1);
  localparam logic [PartW-1:0] MaxNIn = PartW'(MAX_N);

  logic [CountW-1:0] mem [MAX_N:0];

  logic [IdxW-1:0]   n_q, n_d;
  logic [IdxW-1:0]   s_q, s_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic              wr_pend_q;
  logic [IdxW-1:0]   wr_addr_q;
  logic [CountW-1:0] rd_a_q, rd_b_q;
  logic [CountW-1:0] count_q;

  logic              j_last;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [CountW-1:0] mem_wdata;
  logic              rd_en;
  logic [IdxW-1:0]   rd_a_addr, rd_b_addr;

  assign j_last = (j_q == n_q);

  always_comb begin
    n_d = n_q;
    s_d = s_q;
    j_d = j_q;
    if (cmd_i.load) begin
      // clamp n to the table size
      n_d = (part_total_i > MaxNIn) ? IdxW'(MAX_N) : IdxW'(part_total_i);
      j_d = '0;
    end else if (cmd_i.fold_start) begin
      s_d = IdxW'(FirstPart);
      j_d = IdxW'(FirstPart);
    end else if (cmd_i.init) begin
      j_d = j_q + IdxW'(1);
    end else if (cmd_i.fold) begin
      if (j_last) begin
        s_d = s_q + IdxW'(1);
        j_d = s_q + IdxW'(1);
      end else begin
        j_d = j_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      s_q       <= '0;
      j_q       <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      n_q       <= n_d;
      s_q       <= s_d;
      j_q       <= j_d;
      wr_pend_q <= cmd_i.fold;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold) begin
      wr_addr_q <= j_q;
    end
    if (cmd_i.cap) begin
      count_q <= rd_a_q;
    end
  end

  // init writes a one; a fold writes back the sum in the cycle after its reads
  assign mem_we    = cmd_i.init | wr_pend_q;
  assign mem_waddr = cmd_i.init ? j_q : wr_addr_q;
  assign mem_wdata = cmd_i.init ? CountW'(1) : (rd_a_q + rd_b_q);

  assign rd_en     = cmd_i.fold | cmd_i.rd_res;
  assign rd_a_addr = cmd_i.rd_res ? n_q : j_q;
  assign rd_b_addr = j_q - s_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      // take the new sum when port a reads the entry being written back
      if (mem_we && (mem_waddr == rd_a_addr)) begin
        rd_a_q <= mem_wdata;
      end else begin
        rd_a_q <= mem[rd_a_addr];
      end
      rd_b_q <= mem[rd_b_addr];
    end
  end

  assign status_o.j_last    = j_last;
  assign status_o.fold_last = j_last && (s_q == n_q);
  assign status_o.n_small   = (n_q <= IdxW'(1));

  assign partition_count_o = count_q;

  a_no_rw_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_pend_q && cmd_i.fold) |-> (rd_b_addr != wr_addr_q))
    else $error("fold read hits the pending write-back");

  a_fold_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold |-> (j_q >= s_q && j_q <= n_q && s_q >= IdxW'(FirstPart)))
    else $error("fold index out of range");

  a_n_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (n_q <= IdxW'(MAX_N)))
    else $error("n above table size");

endmodule

@@ dv/partition_count_generating_dp_test.sv @@
module partition_count_generating_dp_test
  import pcg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTotal    = 256;
  localparam int unsigned RandomWords = 100;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 3_000_000;

  typedef struct packed {
    logic [PartW-1:0]  total;
    logic              known;
    logic [CountW-1:0] count;
  } total_row_t;

  typedef struct packed {
    logic [PartW-1:0]  total;
    logic [CountW-1:0] count;
  } count_entry_t;

  // Counts are typed in only where they are plain; the rest come from the predictor.
  localparam total_row_t DirectedRows [17] = '{
    '{9'd0,   1'b1, 63'd1},   // empty partition
    '{9'd1,   1'b1, 63'd1},
    '{9'd2,   1'b1, 63'd2},   // first folded part size
    '{9'd3,   1'b1, 63'd3},
    '{9'd4,   1'b1, 63'd5},
    '{9'd5,   1'b1, 63'd7},
    '{9'd10,  1'b1, 63'd42},
    '{9'd256, 1'b0, 63'd0},   // largest total in range
    '{9'd257, 1'b0, 63'd0},   // clamps to the largest total
    '{9'd511, 1'b0, 63'd0},   // all ones, clamps
    '{9'd255, 1'b0, 63'd0},
    '{9'd1,   1'b1, 63'd1},   // nothing to fold after a full table
    '{9'd0,   1'b1, 63'd1},
    '{9'd170, 1'b0, 63'd0},
    '{9'd85,  1'b0, 63'd0},
    '{9'd6,   1'b1, 63'd11},
    '{9'd7,   1'b1, 63'd15}
  };

  logic              clk_i;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic [PartW-1:0]  part_total_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic [CountW-1:0] partition_count_o;

  count_entry_t pending_counts [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles     = 0;

  partition_count_generating_dp #(
    .MAX_N(MaxTotal)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .part_total_i,
    .out_valid_o,
    .out_ready_i,
    .partition_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Same table method: seed every total with the all-ones partition, fold sizes 2..n.
  function automatic logic [CountW-1:0] partition_count_of(input logic [PartW-1:0] total);
    logic [63:0] counts [0:MaxTotal];
    int unsigned n;
    n = (32'(total) > MaxTotal) ? MaxTotal : 32'(total);
    for (int unsigned j = 0; j <= n; j++) counts[j] = 64'd1;
    for (int unsigned s = FirstPart; s <= n; s++) begin
      for (int unsigned j = s; j <= n; j++) counts[j] = counts[j] + counts[j - s];
    end
    return counts[n][CountW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [PartW-1:0] total,
                                 input logic [CountW-1:0] got, input logic [CountW-1:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s, n=%0d got %0d want %0d", cycles, what, total, got,
             want);
  endtask

  task automatic send_total(input logic [PartW-1:0] total, input logic known,
                            input logic [CountW-1:0] known_count);
    int unsigned  gap;
    int unsigned  roll;
    count_entry_t entry;
    roll = $urandom_range(0, 99);
    if (roll < 50) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 300);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    part_total_i <= total;
    do @(posedge clk_i); while (!in_ready_o);
    entry.total = total;
    entry.count = known ? known_count : partition_count_of(total);
    pending_counts.push_back(entry);
  endtask

  initial begin : check_results
    int unsigned  run_left;
    bit           stalling;
    count_entry_t entry;
    run_left = 0;
    stalling = 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("word with none pending", '0, partition_count_o, '0);
        end else begin
          entry = pending_counts.pop_front();
          if (partition_count_o !== entry.count) begin
            report_mismatch("partition_count", entry.total, partition_count_o, entry.count);
          end
        end
      end
      // Alternate ready runs with stalls, mostly short and now and then long.
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling) begin
          run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 300);
        end else begin
          run_left = $urandom_range(1, 40);
        end
      end
      run_left--;
      out_ready_i <= !stalling;
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : run_words
    logic [PartW-1:0] total;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedRows[i]) begin
      send_total(DirectedRows[i].total, DirectedRows[i].known, DirectedRows[i].count);
    end
    // Keep most totals small; a large one every twentieth word bounds the run.
    for (int i = 0; i < RandomWords; i++) begin
      if (i % 20 == 19) total = PartW'($urandom_range(200, 511));
      else if ($urandom_range(0, 3) == 0) total = PartW'($urandom_range(0, 63));
      else total = PartW'($urandom_range(0, 24));
      send_total(total, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ partition_count_generating_dp.f @@
design/pcg_pkg.sv
design/pcg_ctrl.sv
design/pcg_dp.sv
design/partition_count_generating_dp.sv
dv/partition_count_generating_dp_test.sv
